// File: sv/assert_macros.svh
// assertion helpers, clocked on clk and quiet during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define TPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/tpc_pkg.sv
package tpc_pkg;

  localparam int TEMP_W = 16;
  localparam int BOUND_W = 11;
  localparam int IDX_W = 7;
  localparam int NUM_W = 19;
  localparam int DEN2_W = 12;

  localparam logic [BOUND_W-1:0] BOUND_MAX = 11'd1280;
  localparam logic [IDX_W-1:0] IDX_TOP = 7'd118;
  localparam logic [7:0] SCALE2 = 8'd236;

  typedef enum logic {
    REG_LOW_BOUND  = 1'b0,
    REG_HIGH_BOUND = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              zero;
    logic              full;
    logic [NUM_W-1:0]  rem;
    logic [DEN2_W-1:0] dv;
    logic [IDX_W-1:0]  q;
  } div_t;

  localparam logic [23:0] PALETTE [119] = '{
    {8'd0,8'd0,8'd0}, {8'd0,8'd0,8'd36}, {8'd0,8'd0,8'd51}, {8'd0,8'd0,8'd66},
    {8'd0,8'd0,8'd81}, {8'd2,8'd0,8'd90}, {8'd4,8'd0,8'd99}, {8'd7,8'd0,8'd106},
    {8'd11,8'd0,8'd115}, {8'd14,8'd0,8'd119}, {8'd20,8'd0,8'd123}, {8'd27,8'd0,8'd128},
    {8'd33,8'd0,8'd133}, {8'd41,8'd0,8'd137}, {8'd48,8'd0,8'd140}, {8'd55,8'd0,8'd143},
    {8'd61,8'd0,8'd146}, {8'd66,8'd0,8'd149}, {8'd72,8'd0,8'd150}, {8'd78,8'd0,8'd151},
    {8'd84,8'd0,8'd152}, {8'd91,8'd0,8'd153}, {8'd97,8'd0,8'd155}, {8'd104,8'd0,8'd155},
    {8'd110,8'd0,8'd156}, {8'd115,8'd0,8'd157}, {8'd122,8'd0,8'd157},
    {8'd128,8'd0,8'd157}, {8'd134,8'd0,8'd157}, {8'd139,8'd0,8'd157},
    {8'd146,8'd0,8'd156}, {8'd152,8'd0,8'd155}, {8'd157,8'd0,8'd155},
    {8'd162,8'd0,8'd155}, {8'd167,8'd0,8'd154}, {8'd171,8'd0,8'd153},
    {8'd175,8'd1,8'd152}, {8'd178,8'd1,8'd151}, {8'd182,8'd2,8'd149},
    {8'd185,8'd4,8'd149}, {8'd188,8'd5,8'd147}, {8'd191,8'd6,8'd146},
    {8'd193,8'd8,8'd144}, {8'd195,8'd11,8'd142}, {8'd198,8'd13,8'd139},
    {8'd201,8'd17,8'd135}, {8'd203,8'd20,8'd132}, {8'd206,8'd23,8'd127},
    {8'd208,8'd26,8'd121}, {8'd210,8'd29,8'd116}, {8'd212,8'd33,8'd111},
    {8'd214,8'd37,8'd103}, {8'd217,8'd41,8'd97}, {8'd219,8'd46,8'd89},
    {8'd221,8'd49,8'd78}, {8'd223,8'd53,8'd66}, {8'd224,8'd56,8'd54},
    {8'd226,8'd60,8'd42}, {8'd228,8'd64,8'd30}, {8'd229,8'd68,8'd25},
    {8'd231,8'd72,8'd20}, {8'd232,8'd76,8'd16}, {8'd234,8'd78,8'd12},
    {8'd235,8'd82,8'd10}, {8'd236,8'd86,8'd8}, {8'd237,8'd90,8'd7},
    {8'd238,8'd93,8'd5}, {8'd239,8'd96,8'd4}, {8'd240,8'd100,8'd3},
    {8'd241,8'd103,8'd3}, {8'd241,8'd106,8'd2}, {8'd242,8'd109,8'd1},
    {8'd243,8'd113,8'd1}, {8'd244,8'd116,8'd0}, {8'd244,8'd120,8'd0},
    {8'd245,8'd125,8'd0}, {8'd246,8'd129,8'd0}, {8'd247,8'd133,8'd0},
    {8'd248,8'd136,8'd0}, {8'd248,8'd139,8'd0}, {8'd249,8'd142,8'd0},
    {8'd249,8'd145,8'd0}, {8'd250,8'd149,8'd0}, {8'd251,8'd154,8'd0},
    {8'd252,8'd159,8'd0}, {8'd253,8'd163,8'd0}, {8'd253,8'd168,8'd0},
    {8'd253,8'd172,8'd0}, {8'd254,8'd176,8'd0}, {8'd254,8'd179,8'd0},
    {8'd254,8'd184,8'd0}, {8'd254,8'd187,8'd0}, {8'd254,8'd191,8'd0},
    {8'd254,8'd195,8'd0}, {8'd254,8'd199,8'd0}, {8'd254,8'd202,8'd1},
    {8'd254,8'd205,8'd2}, {8'd254,8'd208,8'd5}, {8'd254,8'd212,8'd9},
    {8'd254,8'd216,8'd12}, {8'd255,8'd219,8'd15}, {8'd255,8'd221,8'd23},
    {8'd255,8'd224,8'd32}, {8'd255,8'd227,8'd39}, {8'd255,8'd229,8'd50},
    {8'd255,8'd232,8'd63}, {8'd255,8'd235,8'd75}, {8'd255,8'd238,8'd88},
    {8'd255,8'd239,8'd102}, {8'd255,8'd241,8'd116}, {8'd255,8'd242,8'd134},
    {8'd255,8'd244,8'd149}, {8'd255,8'd245,8'd164}, {8'd255,8'd247,8'd179},
    {8'd255,8'd248,8'd192}, {8'd255,8'd249,8'd203}, {8'd255,8'd251,8'd216},
    {8'd255,8'd253,8'd228}, {8'd255,8'd254,8'd239}
  };

endpackage

// File: sv/thermal_palette_colorizer_core.sv
// Ironbow colorizer: each input word is one signed temperature pixel (1/16 C); each output
// word carries the palette index round((t-low)*118/(high-low)), saturated to 0..118, and its
// 8-bit red, green and blue. One word per clock is accepted and delivered while out_tready
// is held high; the pipeline is offset, scale, four stages of a restoring divider that
// resolves the seven quotient bits two at a time (the last stage one bit), and the palette
// lookup into the output register. Each stage stalls only when it is full and the next
// stage cannot take its word. Bound writes saturate to 0..1280 and are dropped when they
// would cross the other bound; write them only while no pixel is in flight.
`include "assert_macros.svh"

module thermal_palette_colorizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // temperature[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // palette_index[6:0], red[14:7], green[22:15], blue[30:23]
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_wdata
);

  localparam int NDIV = 4;

  logic [tpc_pkg::BOUND_W-1:0] low_r, high_r;
  logic [tpc_pkg::BOUND_W-1:0] cfg_sat;

  // configuration
  assign cfg_sat = (cfg_wdata > tpc_pkg::BOUND_MAX) ? tpc_pkg::BOUND_MAX : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= tpc_pkg::BOUND_MAX;
    end else if (cfg_we) begin
      unique case (tpc_pkg::cfg_reg_t'(cfg_addr))
        tpc_pkg::REG_LOW_BOUND: begin
          if (cfg_sat <= high_r) low_r <= cfg_sat;
        end
        tpc_pkg::REG_HIGH_BOUND: begin
          if (low_r <= cfg_sat) high_r <= cfg_sat;
        end
        default: ;
      endcase
    end
  end

  // stage 1: offset and span
  logic                        v1_r, rdy1;
  logic signed [16:0]          d1_r;
  logic [tpc_pkg::BOUND_W-1:0] den1_r;

  // stage 2: flags and scaled numerator
  logic          v2_r, rdy2;
  tpc_pkg::div_t w2_r, w2_nxt;

  // divider chain
  logic          dv_valid [NDIV+1];
  logic          dv_ready [NDIV+1];
  tpc_pkg::div_t dv_word  [NDIV+1];

  // output stage
  logic                      vo_r, rdyo;
  logic [tpc_pkg::IDX_W-1:0] idx_o_r, idx_nxt;
  logic [23:0]               rgb_o_r;

  assign rdyo      = !vo_r || out_tready;
  assign rdy2      = !v2_r || dv_ready[0];
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      d1_r   <= 17'(signed'(in_tdata)) - signed'({6'd0, low_r});
      den1_r <= high_r - low_r;
    end
  end

  always_comb begin
    w2_nxt      = '0;
    w2_nxt.zero = (d1_r <= 17'sd0);
    w2_nxt.full = (d1_r >= signed'({6'd0, den1_r}));
    w2_nxt.rem  = tpc_pkg::NUM_W'(d1_r[10:0]) * tpc_pkg::NUM_W'(tpc_pkg::SCALE2)
                + tpc_pkg::NUM_W'(den1_r);
    w2_nxt.dv   = {den1_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      w2_r <= w2_nxt;
    end
  end

  assign dv_valid[0]    = v2_r;
  assign dv_word[0]     = w2_r;
  assign dv_ready[NDIV] = rdyo;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    localparam int FB = 6 - 2 * k;
    tpc_div_stage #(
      .FIRST_BIT(FB),
      .STEPS    ((FB >= 1) ? 2 : 1)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (dv_valid[k]),
      .in_word  (dv_word[k]),
      .in_ready (dv_ready[k]),
      .out_valid(dv_valid[k+1]),
      .out_word (dv_word[k+1]),
      .out_ready(dv_ready[k+1])
    );
  end

  always_comb begin
    if (dv_word[NDIV].zero) begin
      idx_nxt = '0;
    end else if (dv_word[NDIV].full) begin
      idx_nxt = tpc_pkg::IDX_TOP;
    end else begin
      idx_nxt = dv_word[NDIV].q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (rdyo) begin
      vo_r <= dv_valid[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (rdyo && dv_valid[NDIV]) begin
      idx_o_r <= idx_nxt;
      rgb_o_r <= tpc_pkg::PALETTE[idx_nxt];
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {1'b0, rgb_o_r[7:0], rgb_o_r[15:8], rgb_o_r[23:16], idx_o_r};

  `TPC_ASSERT(a_bounds_ordered, low_r <= high_r, "low bound above high bound")
  `TPC_ASSERT(a_high_in_range, high_r <= tpc_pkg::BOUND_MAX, "high bound out of range")
  `TPC_ASSERT_IMP(a_idx_range, out_tvalid, out_tdata[6:0] <= tpc_pkg::IDX_TOP,
                  "palette index out of range")
  `TPC_ASSERT_IMP(a_ready_when_drained, !out_tvalid, in_tready,
                  "input stalled with an empty output stage")

endmodule

// File: sv/tpc_div_stage.sv
module tpc_div_stage #(
  parameter int FIRST_BIT = 6,
  parameter int STEPS = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  tpc_pkg::div_t in_word,
  output logic         in_ready,
  output logic         out_valid,
  output tpc_pkg::div_t out_word,
  input  logic         out_ready
);

  logic          v_r;
  tpc_pkg::div_t w_r;
  tpc_pkg::div_t w_nxt;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_word  = w_r;

  // restoring division, one quotient bit per step
  always_comb begin
    logic [tpc_pkg::NUM_W-1:0] sh;
    w_nxt = in_word;
    for (int j = 0; j < STEPS; j++) begin
      sh = tpc_pkg::NUM_W'(w_nxt.dv) << (FIRST_BIT - j);
      if (w_nxt.rem >= sh) begin
        w_nxt.rem = w_nxt.rem - sh;
        w_nxt.q[FIRST_BIT - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      w_r <= w_nxt;
    end
  end

endmodule

// File: dv/thermal_palette_colorizer_core_tb.sv
`timescale 1ns / 1ps

module thermal_palette_colorizer_core_tb;

  typedef struct packed {
    logic [tpc_pkg::IDX_W-1:0] idx;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
  } color_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = tpc_pkg::REG_LOW_BOUND;
  logic [10:0] cfg_wdata = '0;

  thermal_palette_colorizer_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [15:0] pixel_q[$];
  color_t      color_q[$];
  int          low_reg, high_reg;
  int          mismatches = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          hold_in = 1'b0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int clamp_bound(logic [10:0] v);
    return int'((v > tpc_pkg::BOUND_MAX) ? tpc_pkg::BOUND_MAX : v);
  endfunction

  function automatic color_t colorize(logic [15:0] raw);
    int t, d, den, q;
    color_t c;
    t = int'($signed(raw));
    d = t - low_reg;
    den = high_reg - low_reg;
    if (d <= 0) q = 0;
    else if (den <= 0) q = 118;
    else begin
      q = (2 * d * 118 + den) / (2 * den);
      if (q > 118) q = 118;
    end
    c.idx = 7'(q);
    {c.red, c.green, c.blue} = tpc_pkg::PALETTE[q];
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) color_q.push_back(colorize(in_tdata));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0 && !hold_in) begin
        in_tdata <= pixel_q.pop_front();
        in_tvalid <= 1'b1;
        in_gap <= gap_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    color_t got, exp_c;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.idx = out_tdata[6:0];
        got.red = out_tdata[14:7];
        got.green = out_tdata[22:15];
        got.blue = out_tdata[30:23];
        if (color_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_tdata);
        end else begin
          exp_c = color_q.pop_front();
          if (got !== exp_c) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp idx %0d rgb %0d/%0d/%0d got idx %0d rgb %0d/%0d/%0d",
                       exp_c.idx, exp_c.red, exp_c.green, exp_c.blue,
                       got.idx, got.red, got.green, got.blue);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap <= gap_len();
      end
    end
  end

  task automatic drain();
    while (pixel_q.size() > 0 || in_tvalid || color_q.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_bound(tpc_pkg::cfg_reg_t r, logic [10:0] v);
    int s;
    s = clamp_bound(v);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == tpc_pkg::REG_LOW_BOUND) begin
      if (s <= high_reg) low_reg = s;
    end else if (low_reg <= s) high_reg = s;
  endtask

  task automatic random_pixels(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 7) pixel_q.push_back(16'($signed($urandom_range(0, 1400)) - 60));
      else pixel_q.push_back(16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] directed[$];
    low_reg = 0;
    high_reg = int'(tpc_pkg::BOUND_MAX);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed = {16'h8000, 16'h7fff, 16'hffff, 16'h0000, 16'h0001, 16'd640, 16'd1279,
                16'd1280, 16'd1281, 16'h5555, 16'haaaa, 16'd5, 16'd6};
    foreach (directed[i]) pixel_q.push_back(directed[i]);
    drain();
    // out-of-range writes saturate, leaving both bounds at 1280
    write_bound(tpc_pkg::REG_HIGH_BOUND, 11'h7ff);
    write_bound(tpc_pkg::REG_LOW_BOUND, 11'd1500);
    pixel_q.push_back(16'd1279);
    pixel_q.push_back(16'd1281);
    pixel_q.push_back(16'd1280);
    drain();
    write_bound(tpc_pkg::REG_LOW_BOUND, 11'd0);
    write_bound(tpc_pkg::REG_HIGH_BOUND, 11'd400);
    write_bound(tpc_pkg::REG_LOW_BOUND, 11'd500);
    write_bound(tpc_pkg::REG_LOW_BOUND, 11'd400);
    // equal bounds
    pixel_q.push_back(16'd399);
    pixel_q.push_back(16'd400);
    pixel_q.push_back(16'd401);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_bound(tpc_pkg::REG_LOW_BOUND, 11'd0);
      write_bound(tpc_pkg::REG_HIGH_BOUND, 11'($urandom_range(0, 2047)));
      write_bound(tpc_pkg::REG_LOW_BOUND, 11'($urandom_range(0, 1300)));
      random_pixels(60);
      drain();
    end
    write_bound(tpc_pkg::REG_LOW_BOUND, 11'd0);
    write_bound(tpc_pkg::REG_HIGH_BOUND, 11'd1);
    random_pixels(30);
    drain();
    write_bound(tpc_pkg::REG_HIGH_BOUND, 11'd1280);
    write_bound(tpc_pkg::REG_LOW_BOUND, 11'd1279);
    random_pixels(30);
    drain();
    write_bound(tpc_pkg::REG_LOW_BOUND, 11'd160);
    write_bound(tpc_pkg::REG_HIGH_BOUND, 11'd960);
    random_pixels(120);
    // pause the sender mid-stream until the pipeline has emptied
    wait (pixel_q.size() <= 60);
    hold_in = 1'b1;
    while (in_tvalid || color_q.size() > 0) @(posedge clk);
    hold_in = 1'b0;
    drain();
    if (mismatches == 0 && color_q.size() == 0)
      $display("thermal_palette_colorizer_core regression: pass");
    else
      $display("thermal_palette_colorizer_core regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("thermal_palette_colorizer_core regression: fail");
    $finish;
  end

endmodule
